[rtl/acgo_pkg.sv]
package acgo_pkg;

  // Field widths fixed by the converter word format and the result format.
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned SAMPLE_W = 13;
  localparam int unsigned ACC_W    = 15;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned AVG_W    = 13;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned OFS_W    = 8;
  localparam int unsigned PROD_W   = 22;
  localparam int unsigned SCALED_W = 15;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned SLOTS    = 4;

  // Queue between the accumulating front and the scaling back.
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;
  localparam int unsigned QCNT_W   = 3;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_NEG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_POS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_NEG     = 3'd6;

  // Calibration settings seen by the back end.
  typedef struct packed {
    logic        differential_mode;
    logic [31:0] single_gains;
    logic [31:0] single_pos_offsets;
    logic [31:0] single_neg_offsets;
    logic [15:0] pair_gains;
    logic [15:0] pair_pos_offsets;
    logic [15:0] pair_neg_offsets;
  } acgo_cfg_t;

  // One completed averaging window waiting for calibration.
  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic [CHAN_W-1:0]       channel;
    logic signed [ACC_W-1:0] sum;
  } acgo_item_t;

endpackage

[rtl/acgo_front.sv]
module acgo_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_raw_word,
  input  logic [1:0]                 in_slot,
  input  logic [1:0]                 in_channel,
  input  logic                       in_first_pass,
  input  logic                       in_last_pass,
  input  logic                       q_full,
  output logic                       q_push,
  output acgo_pkg::acgo_item_t       q_item
);

  logic [acgo_pkg::ACC_W-1:0] acc_r [acgo_pkg::SLOTS];
  logic [acgo_pkg::ACC_W-1:0] acc_nxt;
  logic [acgo_pkg::ACC_W-1:0] base;
  logic [acgo_pkg::ACC_W-1:0] sample_ext;
  logic                       accept;

  // A request is taken whenever the queue can hold a possible result.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Sign-extend the 13-bit sample and add it into the slot's running sum.
  assign sample_ext = {{(acgo_pkg::ACC_W - acgo_pkg::SAMPLE_W){in_raw_word[12]}},
                       in_raw_word[acgo_pkg::SAMPLE_W-1:0]};
  assign base       = in_first_pass ? '0 : acc_r[in_slot];
  assign acc_nxt    = base + sample_ext;

  // The last pass hands the finished sum to the back end.
  assign q_push         = accept && in_last_pass;
  assign q_item.slot    = in_slot;
  assign q_item.channel = in_channel;
  assign q_item.sum     = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < acgo_pkg::SLOTS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (accept) begin
      acc_r[in_slot] <= acc_nxt;
    end
  end

endmodule

[rtl/acgo_queue.sv]
module acgo_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  acgo_pkg::acgo_item_t push_item,
  output logic                 full,
  output logic                 pop_valid,
  input  logic                 pop,
  output acgo_pkg::acgo_item_t pop_item
);

  acgo_pkg::acgo_item_t             entry_r [acgo_pkg::QDEPTH];
  logic [acgo_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [acgo_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [acgo_pkg::QCNT_W-1:0]      count_r;
  logic [acgo_pkg::QCNT_W-1:0]      count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (count_r == acgo_pkg::QCNT_W'(acgo_pkg::QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/acgo_back.sv]
module acgo_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acgo_pkg::acgo_cfg_t  cfg,
  input  logic                 q_valid,
  input  acgo_pkg::acgo_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_slot,
  output logic [1:0]           out_result_channel,
  output logic signed [15:0]   out_calibrated_value
);

  // Stage 1: average and calibration selection.
  logic                                s1_valid_r;
  logic [acgo_pkg::SLOT_W-1:0]         s1_slot_r;
  logic [acgo_pkg::CHAN_W-1:0]         s1_chan_r;
  logic signed [acgo_pkg::AVG_W-1:0]   s1_avg_r;
  logic [acgo_pkg::GAIN_W-1:0]         s1_gain_r;
  logic signed [acgo_pkg::OFS_W-1:0]   s1_pos_r;
  logic signed [acgo_pkg::OFS_W-1:0]   s1_neg_r;
  logic                                s1_diff_r;

  // Stage 2: gain product.
  logic                                s2_valid_r;
  logic [acgo_pkg::SLOT_W-1:0]         s2_slot_r;
  logic [acgo_pkg::CHAN_W-1:0]         s2_chan_r;
  logic signed [acgo_pkg::PROD_W-1:0]  s2_prod_r;
  logic signed [acgo_pkg::OFS_W-1:0]   s2_pos_r;
  logic signed [acgo_pkg::OFS_W-1:0]   s2_neg_r;
  logic                                s2_diff_r;

  // Output register.
  logic                                out_valid_r;
  logic [acgo_pkg::SLOT_W-1:0]         out_slot_r;
  logic [acgo_pkg::CHAN_W-1:0]         out_chan_r;
  logic signed [acgo_pkg::VALUE_W-1:0] out_value_r;

  logic                                out_adv;
  logic                                s2_adv;
  logic                                s1_adv;

  logic signed [15:0]                  sum_biased;
  logic signed [acgo_pkg::AVG_W-1:0]   avg;
  logic [4:0]                          sel_shift;
  logic [acgo_pkg::GAIN_W-1:0]         gain_sel;
  logic signed [acgo_pkg::OFS_W-1:0]   pos_sel;
  logic signed [acgo_pkg::OFS_W-1:0]   neg_sel;
  logic signed [acgo_pkg::PROD_W-1:0]  prod;
  logic signed [acgo_pkg::PROD_W-1:0]  prod_biased;
  logic signed [acgo_pkg::SCALED_W-1:0] scaled;
  logic signed [acgo_pkg::OFS_W-1:0]   ofs;
  logic signed [acgo_pkg::VALUE_W-1:0] corrected;
  logic signed [acgo_pkg::VALUE_W-1:0] value;

  // Each stage moves on when the one after it is empty or moving.
  assign out_adv = !out_valid_r || out_ready;
  assign s2_adv  = !s2_valid_r || out_adv;
  assign s1_adv  = !s1_valid_r || s2_adv;
  assign q_pop   = q_valid && s1_adv;

  // Divide the sum by the window of four, truncating toward zero.
  assign sum_biased = {q_item.sum[acgo_pkg::ACC_W-1], q_item.sum}
                    + (q_item.sum[acgo_pkg::ACC_W-1] ? 16'sd3 : 16'sd0);
  assign avg        = sum_biased[14:2];

  // Pick the gain and offsets of the channel, or of the pair in differential mode.
  always_comb begin
    if (cfg.differential_mode) begin
      sel_shift = {1'b0, q_item.channel[0], 3'b000};
      gain_sel  = 8'(cfg.pair_gains >> sel_shift);
      pos_sel   = 8'(cfg.pair_pos_offsets >> sel_shift);
      neg_sel   = 8'(cfg.pair_neg_offsets >> sel_shift);
    end else begin
      sel_shift = {q_item.channel, 3'b000};
      gain_sel  = 8'(cfg.single_gains >> sel_shift);
      pos_sel   = 8'(cfg.single_pos_offsets >> sel_shift);
      neg_sel   = 8'(cfg.single_neg_offsets >> sel_shift);
    end
  end

  // Unsigned gain applied to the signed average.
  assign prod = s1_avg_r * $signed({1'b0, s1_gain_r});

  // Divide by 128 toward zero, then add the offset chosen by the sign.
  assign prod_biased = s2_prod_r + (s2_prod_r[acgo_pkg::PROD_W-1] ? 22'sd127 : 22'sd0);
  assign scaled      = prod_biased[acgo_pkg::PROD_W-1:7];
  assign ofs         = scaled[acgo_pkg::SCALED_W-1] ? s2_neg_r : s2_pos_r;
  assign corrected   = {scaled[acgo_pkg::SCALED_W-1], scaled}
                     + {{(acgo_pkg::VALUE_W - acgo_pkg::OFS_W){ofs[acgo_pkg::OFS_W-1]}}, ofs};
  assign value       = s2_diff_r ? {corrected[acgo_pkg::VALUE_W-2:0], 1'b0} : corrected;

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_valid;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_slot_r <= q_item.slot;
      s1_chan_r <= q_item.channel;
      s1_avg_r  <= avg;
      s1_gain_r <= gain_sel;
      s1_pos_r  <= pos_sel;
      s1_neg_r  <= neg_sel;
      s1_diff_r <= cfg.differential_mode;
    end
    if (s2_adv) begin
      s2_slot_r <= s1_slot_r;
      s2_chan_r <= s1_chan_r;
      s2_prod_r <= prod;
      s2_pos_r  <= s1_pos_r;
      s2_neg_r  <= s1_neg_r;
      s2_diff_r <= s1_diff_r;
    end
    if (out_adv) begin
      out_slot_r  <= s2_slot_r;
      out_chan_r  <= s2_chan_r;
      out_value_r <= value;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_slot      = out_slot_r;
  assign out_result_channel   = out_chan_r;
  assign out_calibrated_value = out_value_r;

endmodule

[rtl/adc_average_gain_offset_calibrator_core.sv]
// Averaging converter calibrator. Every request carries one raw converter word, whose
// 13-bit two's complement sample is added into the accumulator of its slot (a first
// pass restarts it); a request with the last pass set yields one result that reaches
// the output via the queue, stage 1, stage 2 and the output register, held while it
// stalls: the sum divided by four toward zero, scaled by the channel's gain over
// 128 toward zero, corrected by the positive or negative offset and doubled in
// differential mode, where pair = channel bit 0. One request is taken every clock
// cycle; the accumulators update in that same cycle and a four-entry queue feeds a
// three-stage scaling pipeline (average, multiply, offset), so input stalls only when
// that queue fills behind a stalled output. The user writes configuration registers
// via the always-ready cfg port only while the block is idle; it is not enforced.
module adc_average_gain_offset_calibrator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_word,
  input  logic [1:0]         in_slot,
  input  logic [1:0]         in_channel,
  input  logic               in_first_pass,
  input  logic               in_last_pass,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_slot,
  output logic [1:0]         out_result_channel,
  output logic signed [15:0] out_calibrated_value
);

  acgo_pkg::acgo_cfg_t  cfg_r;
  acgo_pkg::acgo_item_t push_item;
  acgo_pkg::acgo_item_t pop_item;
  logic                 q_full;
  logic                 q_push;
  logic                 q_valid;
  logic                 q_pop;

  assign cfg_ready = 1'b1;

  // Calibration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.differential_mode  <= 1'b0;
      cfg_r.single_gains       <= 32'h8080_8080;
      cfg_r.single_pos_offsets <= '0;
      cfg_r.single_neg_offsets <= '0;
      cfg_r.pair_gains         <= 16'h8080;
      cfg_r.pair_pos_offsets   <= '0;
      cfg_r.pair_neg_offsets   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acgo_pkg::REG_DIFF_MODE:   cfg_r.differential_mode  <= cfg_data[0];
        acgo_pkg::REG_SINGLE_GAIN: cfg_r.single_gains       <= cfg_data;
        acgo_pkg::REG_SINGLE_POS:  cfg_r.single_pos_offsets <= cfg_data;
        acgo_pkg::REG_SINGLE_NEG:  cfg_r.single_neg_offsets <= cfg_data;
        acgo_pkg::REG_PAIR_GAIN:   cfg_r.pair_gains         <= cfg_data[15:0];
        acgo_pkg::REG_PAIR_POS:    cfg_r.pair_pos_offsets   <= cfg_data[15:0];
        acgo_pkg::REG_PAIR_NEG:    cfg_r.pair_neg_offsets   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  acgo_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_word   (in_raw_word),
    .in_slot       (in_slot),
    .in_channel    (in_channel),
    .in_first_pass (in_first_pass),
    .in_last_pass  (in_last_pass),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  acgo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (pop_item)
  );

  acgo_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (pop_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_slot      (out_result_slot),
    .out_result_channel   (out_result_channel),
    .out_calibrated_value (out_calibrated_value)
  );

endmodule
